// ----- rtl/core/pla_pkg.sv -----
// Shared types, codes and constants for the Phong light accumulator.
// No dependencies; the top level and the checker refer to it by scoped names.
package pla_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int LN2_Q16       = 45426;
    localparam int ONE_Q16       = 65536;
    localparam int SHINE_RST     = 30;
    localparam int CFG_W         = 17;

    typedef enum logic [1:0] {
        OP_HIT    = 2'd0,
        OP_NORMAL = 2'd1,
        OP_REFL   = 2'd2,
        OP_LIGHT  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_RED      = 3'd0,
        CFG_GREEN    = 3'd1,
        CFG_BLUE     = 3'd2,
        CFG_AMBIENT  = 3'd3,
        CFG_DIFFUSE  = 3'd4,
        CFG_SPECULAR = 3'd5,
        CFG_SHINE    = 3'd6,
        CFG_FLOOR    = 3'd7
    } t_cfg_idx;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ, S_SQRT, S_DIV, S_FALL, S_RED, S_TMUL, S_TDIV, S_DOT,
        S_DIF1, S_DIF2, S_PINIT, S_POW, S_SPC1, S_SPC2, S_OUT, S_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] vec_z;
        logic [19:0]        falloff_rate;
        logic               last_light;
    } t_in;

    typedef struct packed {
        logic [23:0] shade_red;
        logic [23:0] shade_green;
        logic [23:0] shade_blue;
        logic [16:0] ambient_red;
        logic [16:0] ambient_green;
        logic [16:0] ambient_blue;
    } t_out;

endpackage

// ----- rtl/core/pla_mul.sv -----
// Shared multiplier: 64 x 32 product over two passes of one 32 x 32 array.
// Depends on nothing beyond the clock and reset.
module pla_mul (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [63:0] o_p
);
    logic        r_ph;
    logic        r_done;
    logic [31:0] r_hi;
    logic [31:0] r_b;
    logic [63:0] r_acc;
    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] prod;

    assign mul_x  = i_start ? i_a[31:0] : r_hi;
    assign mul_y  = i_start ? i_b : r_b;
    assign prod   = mul_x * mul_y;
    assign o_done = r_done;
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph   <= i_start;
            r_done <= r_ph;
        end
        if (i_start) begin
            r_acc <= prod;
            r_hi  <= i_a[63:32];
            r_b   <= i_b;
        end else if (r_ph) begin
            r_acc <= r_acc + {prod[31:0], 32'b0};
        end
    end
endmodule

// ----- rtl/core/pla_div.sv -----
// Restoring divider, one quotient bit a cycle, quotient width set per request.
// Depends on nothing beyond the clock and reset.
module pla_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [47:0] i_dividend,
    input  logic [31:0] i_divisor,
    input  logic [5:0]  i_qbits,
    output logic        o_done,
    output logic [47:0] o_quo
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [31:0] r_rem;
    logic [31:0] r_div;
    logic [47:0] r_quo;
    logic [47:0] start_rem;
    logic [32:0] rem2;
    logic        fits;

    assign start_rem = i_dividend >> i_qbits;
    assign rem2      = {r_rem, r_quo[47]};
    assign fits      = rem2 >= {1'b0, r_div};
    assign o_done    = r_done;
    assign o_quo     = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rem <= start_rem[31:0];
            r_quo <= i_dividend << (6'd48 - i_qbits);
            r_div <= i_divisor;
            r_cnt <= i_qbits;
        end else if (r_busy) begin
            r_rem <= fits ? 32'(rem2 - {1'b0, r_div}) : rem2[31:0];
            r_quo <= {r_quo[46:0], fits};
            r_cnt <= r_cnt - 6'd1;
        end
    end
endmodule

// ----- rtl/core/pla_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// Depends on nothing beyond the clock and reset.
module pla_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic        r_busy;
    logic        r_done;
    logic [5:0]  r_cnt;
    logic [63:0] r_rad;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [34:0] rem2;
    logic [34:0] trial;
    logic        fits;

    assign rem2   = {r_rem[32:0], r_rad[63:62]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = rem2 >= trial;
    assign o_done = r_done;
    assign o_root = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd1) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= 6'd32;
        end else if (r_busy) begin
            r_rad  <= {r_rad[61:0], 2'b00};
            r_rem  <= fits ? rem2 - trial : rem2;
            r_root <= {r_root[30:0], fits};
            r_cnt  <= r_cnt - 6'd1;
        end
    end
endmodule

// ----- rtl/core/phong_light_accumulate_top.sv -----
// Phong light accumulator top level: sequencer, state and configuration.
// Depends on pla_pkg, pla_mul, pla_div and pla_sqrt.
//
// Input channel i_in_valid / o_in_stall carries load and light requests.
// Hit point and normal loads are stored without leaving the idle state. A
// reflected direction takes three squares, a 32-step root and three
// 17-step divisions. A light takes those plus the falloff: up to 17
// reduction steps and ten series terms, six dot products, the diffuse
// and specular products and up to shine_exponent power steps.
// Every product goes through the one shared multiplier; quotients and
// the root come from the bit-serial divider and root units.
// A last light adds nine colour products and loads the output register,
// which holds a result until the receiver takes it; o_out_valid /
// i_out_stall form the output channel, and while a result is stalled the
// next request is still accepted and worked on.
// o_in_stall is high whenever the sequencer is busy.
// Synchronous reset restores the register defaults and clears the hit
// point, normal, reflected direction and diffuse and specular sums;
// configuration writes are taken on any cycle with i_cfg_we.
module phong_light_accumulate_top #(
    parameter int FRAC_BITS = pla_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pla_pkg::t_in                   i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pla_pkg::t_out                  o_out_data,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_idx,
    input  logic [pla_pkg::CFG_W-1:0]      i_cfg_data
);
    localparam int D2_SHIFT = 2 * FRAC_BITS - 16;

    pla_pkg::t_state r_state, n_state;

    logic [16:0] r_col [3];
    logic [16:0] r_amb_coef, r_dif_coef, r_spc_coef;
    logic [7:0]  r_shine;
    logic        r_floor;

    logic signed [31:0] r_hit [3];
    logic signed [31:0] r_nrm [3];
    logic [16:0]        r_rmag [3];
    logic               r_rneg [3];

    logic [31:0] r_mag [3];
    logic        r_neg [3];
    logic [16:0] r_dmag [3];
    logic [19:0] r_fall;
    logic        r_last, r_light;
    logic [63:0] r_d2;
    logic [31:0] r_d;
    logic [23:0] r_x;
    logic [4:0]  r_n;
    logic [3:0]  r_ti;
    logic [31:0] r_term, r_tsum;
    logic [63:0] r_tmp;
    logic [16:0] r_scale;
    logic signed [50:0] r_dot;
    logic signed [35:0] r_rd;
    logic [16:0] r_c, r_p;
    logic [7:0]  r_k;
    logic [31:0] r_lam, r_pho;
    logic [2:0]  r_idx;
    logic [1:0]  r_sub;
    logic [33:0] r_acc;
    logic [23:0] r_shade [3];
    logic [16:0] r_amb [3];
    logic        r_go;
    logic        r_out_valid;
    pla_pkg::t_out r_out;

    logic        in_acc, out_acc, adv, emit;
    logic        mul_start, div_start, sq_start;
    logic [63:0] m_a;
    logic [31:0] m_b;
    logic [47:0] d_dividend;
    logic [31:0] d_divisor;
    logic [5:0]  d_qbits;
    logic        mul_done, div_done, sq_done;
    logic [63:0] mul_p;
    logic [47:0] div_q;
    logic [31:0] sq_root;

    logic signed [31:0] vin [3];
    logic [31:0] vmag [3];
    logic        vneg [3];
    logic [1:0]  sel;
    logic [63:0] d2q;
    logic        d2q_big;
    logic [63:0] xfull;
    logic [31:0] tsum_nx;
    logic [31:0] scale_full;
    logic [63:0] dq;
    logic [17:0] rd_hi;
    logic [31:0] nmag;
    logic [47:0] prod_hi;
    logic [48:0] lam_sum, pho_sum;
    logic [34:0] acc_sum;
    logic [47:0] amb_val;
    logic [16:0] q_clamp;
    logic        pow_end;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != pla_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign emit = (r_state == pla_pkg::S_EMIT) && (!r_out_valid || !i_out_stall);

    assign vin[0] = i_in_data.vec_x;
    assign vin[1] = i_in_data.vec_y;
    assign vin[2] = i_in_data.vec_z;

    always_comb begin
        logic signed [32:0] diff;
        logic signed [32:0] t;
        for (int i = 0; i < 3; i++) begin
            diff = 33'(vin[i]) - 33'(r_hit[i]);
            if (i_in_data.op != pla_pkg::OP_LIGHT) begin
                t = 33'(vin[i]);
            end else if (diff > 33'sd2147483647) begin
                t = 33'sd2147483647;
            end else if (diff < -33'sd2147483647) begin
                t = -33'sd2147483647;
            end else begin
                t = diff;
            end
            vneg[i] = t[32];
            vmag[i] = t[32] ? 32'(-t) : t[31:0];
        end
    end

    assign sel        = (r_idx >= 3'd3) ? 2'(r_idx - 3'd3) : r_idx[1:0];
    assign d2q        = r_d2 >> D2_SHIFT;
    assign d2q_big    = |d2q[63:44];
    assign xfull      = mul_p >> 16;
    assign tsum_nx    = r_ti[0] ? r_tsum - div_q[31:0] : r_tsum + div_q[31:0];
    assign scale_full = tsum_nx >> (5'd14 + r_n);
    assign dq         = 64'(unsigned'(r_dot)) >> FRAC_BITS;
    assign rd_hi      = 18'(unsigned'(r_rd) >> 16);
    assign nmag       = r_nrm[sel][31] ? 32'(-r_nrm[sel]) : r_nrm[sel];
    assign prod_hi    = mul_p[63:16];
    assign lam_sum    = 49'(r_lam) + 49'(prod_hi);
    assign pho_sum    = 49'(r_pho) + 49'(prod_hi);
    assign acc_sum    = 35'(r_acc) + (r_floor ? 35'd0 : 35'(prod_hi));
    assign amb_val    = prod_hi;
    assign q_clamp    = (div_q > 48'(pla_pkg::ONE_Q16)) ? 17'(pla_pkg::ONE_Q16) : div_q[16:0];
    assign pow_end    = (r_k == r_shine) || (r_p == 17'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pla_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        adv        = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        sq_start   = 1'b0;
        m_a        = '0;
        m_b        = '0;
        d_dividend = '0;
        d_divisor  = '0;
        d_qbits    = '0;
        unique case (r_state)
            pla_pkg::S_IDLE: begin
                if (in_acc && (i_in_data.op == pla_pkg::OP_LIGHT ||
                               i_in_data.op == pla_pkg::OP_REFL)) begin
                    n_state = pla_pkg::S_SQ;
                end
            end
            pla_pkg::S_SQ: begin
                m_a = {32'b0, r_mag[r_idx[1:0]]};
                m_b = r_mag[r_idx[1:0]];
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv && r_idx == 3'd2) begin
                    n_state = pla_pkg::S_SQRT;
                end
            end
            pla_pkg::S_SQRT: begin
                sq_start = !r_go;
                adv = r_go && sq_done;
                if (adv) begin
                    n_state = pla_pkg::S_DIV;
                end
            end
            pla_pkg::S_DIV: begin
                d_dividend = {r_mag[r_idx[1:0]], 16'b0};
                d_divisor  = r_d;
                d_qbits    = 6'd17;
                div_start  = !r_go && (r_d != 32'd0);
                adv = (r_d == 32'd0) || (r_go && div_done);
                if (adv && r_idx == 3'd2) begin
                    n_state = r_light ? pla_pkg::S_FALL : pla_pkg::S_IDLE;
                end
            end
            pla_pkg::S_FALL: begin
                m_a = d2q;
                m_b = {12'b0, r_fall};
                if (r_fall == 20'd0 || d2q_big) begin
                    adv = 1'b1;
                    n_state = pla_pkg::S_DOT;
                end else begin
                    mul_start = !r_go;
                    adv = r_go && mul_done;
                    if (adv) begin
                        n_state = (|xfull[63:24]) ? pla_pkg::S_DOT : pla_pkg::S_RED;
                    end
                end
            end
            pla_pkg::S_RED: begin
                adv = 1'b1;
                if (r_x >= 24'(pla_pkg::LN2_Q16)) begin
                    if (r_n == 5'd16) begin
                        n_state = pla_pkg::S_DOT;
                    end
                end else begin
                    n_state = pla_pkg::S_TMUL;
                end
            end
            pla_pkg::S_TMUL: begin
                m_a = {32'b0, r_term};
                m_b = {8'b0, r_x};
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv) begin
                    n_state = pla_pkg::S_TDIV;
                end
            end
            pla_pkg::S_TDIV: begin
                d_dividend = r_tmp[47:0];
                d_divisor  = {28'b0, r_ti};
                d_qbits    = 6'd30;
                div_start  = !r_go;
                adv = r_go && div_done;
                if (adv) begin
                    n_state = (r_ti == 4'd10) ? pla_pkg::S_DOT : pla_pkg::S_TMUL;
                end
            end
            pla_pkg::S_DOT: begin
                if (r_idx < 3'd3) begin
                    m_a = {47'b0, r_dmag[sel]};
                    m_b = nmag;
                end else begin
                    m_a = {47'b0, r_dmag[sel]};
                    m_b = {15'b0, r_rmag[sel]};
                end
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv && r_idx == 3'd5) begin
                    n_state = pla_pkg::S_DIF1;
                end
            end
            pla_pkg::S_DIF1: begin
                m_a = dq;
                m_b = {15'b0, r_dif_coef};
                if (r_dot <= 51'sd0) begin
                    adv = 1'b1;
                    n_state = pla_pkg::S_PINIT;
                end else begin
                    mul_start = !r_go;
                    adv = r_go && mul_done;
                    if (adv) begin
                        n_state = pla_pkg::S_DIF2;
                    end
                end
            end
            pla_pkg::S_DIF2: begin
                m_a = r_tmp;
                m_b = {15'b0, r_scale};
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv) begin
                    n_state = pla_pkg::S_PINIT;
                end
            end
            pla_pkg::S_PINIT: begin
                adv = 1'b1;
                n_state = pla_pkg::S_POW;
            end
            pla_pkg::S_POW: begin
                m_a = {47'b0, r_p};
                m_b = {15'b0, r_c};
                if (pow_end) begin
                    adv = 1'b1;
                    n_state = pla_pkg::S_SPC1;
                end else begin
                    mul_start = !r_go;
                    adv = r_go && mul_done;
                end
            end
            pla_pkg::S_SPC1: begin
                m_a = {47'b0, r_p};
                m_b = {15'b0, r_scale};
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv) begin
                    n_state = pla_pkg::S_SPC2;
                end
            end
            pla_pkg::S_SPC2: begin
                m_a = r_tmp;
                m_b = {15'b0, r_spc_coef};
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv) begin
                    n_state = r_last ? pla_pkg::S_OUT : pla_pkg::S_IDLE;
                end
            end
            pla_pkg::S_OUT: begin
                m_b = {15'b0, r_col[r_idx[1:0]]};
                case (r_sub)
                    2'd0:    m_a = {32'b0, r_lam};
                    2'd1:    m_a = {32'b0, r_pho};
                    default: m_a = {47'b0, r_amb_coef};
                endcase
                mul_start = !r_go;
                adv = r_go && mul_done;
                if (adv && r_sub == 2'd2 && r_idx == 3'd2) begin
                    n_state = pla_pkg::S_EMIT;
                end
            end
            pla_pkg::S_EMIT: begin
                if (emit) begin
                    n_state = pla_pkg::S_IDLE;
                end
            end
            default: n_state = pla_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0]    <= 17'(pla_pkg::ONE_Q16);
            r_col[1]    <= 17'(pla_pkg::ONE_Q16);
            r_col[2]    <= 17'(pla_pkg::ONE_Q16);
            r_amb_coef  <= '0;
            r_dif_coef  <= '0;
            r_spc_coef  <= '0;
            r_shine     <= 8'(pla_pkg::SHINE_RST);
            r_floor     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (pla_pkg::t_cfg_idx'(i_cfg_idx))
                pla_pkg::CFG_RED:      r_col[0]   <= i_cfg_data;
                pla_pkg::CFG_GREEN:    r_col[1]   <= i_cfg_data;
                pla_pkg::CFG_BLUE:     r_col[2]   <= i_cfg_data;
                pla_pkg::CFG_AMBIENT:  r_amb_coef <= i_cfg_data;
                pla_pkg::CFG_DIFFUSE:  r_dif_coef <= i_cfg_data;
                pla_pkg::CFG_SPECULAR: r_spc_coef <= i_cfg_data;
                pla_pkg::CFG_SHINE:    r_shine    <= i_cfg_data[7:0];
                pla_pkg::CFG_FLOOR:    r_floor    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (mul_start || div_start || sq_start) begin
                r_go <= 1'b1;
            end else if (adv) begin
                r_go <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_hit[i]  <= '0;
                r_nrm[i]  <= '0;
                r_rmag[i] <= '0;
                r_rneg[i] <= 1'b0;
            end
            r_lam <= '0;
            r_pho <= '0;
        end else begin
            case (r_state)
                pla_pkg::S_IDLE: begin
                    if (in_acc) begin
                        if (i_in_data.op == pla_pkg::OP_HIT) begin
                            for (int i = 0; i < 3; i++) r_hit[i] <= vin[i];
                        end else if (i_in_data.op == pla_pkg::OP_NORMAL) begin
                            for (int i = 0; i < 3; i++) r_nrm[i] <= vin[i];
                        end
                    end
                end
                pla_pkg::S_DIV: begin
                    if (adv && !r_light) begin
                        r_rmag[r_idx[1:0]] <= (r_d == 32'd0) ? 17'd0 : q_clamp;
                        r_rneg[r_idx[1:0]] <= r_neg[r_idx[1:0]];
                    end
                end
                pla_pkg::S_DIF2: begin
                    if (adv) begin
                        r_lam <= (|lam_sum[48:32]) ? 32'hFFFF_FFFF : lam_sum[31:0];
                    end
                end
                pla_pkg::S_SPC2: begin
                    if (adv) begin
                        r_pho <= (|pho_sum[48:32]) ? 32'hFFFF_FFFF : pho_sum[31:0];
                    end
                end
                pla_pkg::S_EMIT: begin
                    if (emit) begin
                        r_lam <= '0;
                        r_pho <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            pla_pkg::S_IDLE: begin
                if (in_acc) begin
                    for (int i = 0; i < 3; i++) begin
                        r_mag[i] <= vmag[i];
                        r_neg[i] <= vneg[i];
                    end
                    r_fall  <= i_in_data.falloff_rate;
                    r_last  <= i_in_data.last_light;
                    r_light <= (i_in_data.op == pla_pkg::OP_LIGHT);
                    r_d2    <= '0;
                    r_idx   <= '0;
                end
            end
            pla_pkg::S_SQ: begin
                if (adv) begin
                    r_d2  <= r_d2 + mul_p;
                    r_idx <= (r_idx == 3'd2) ? 3'd0 : r_idx + 3'd1;
                end
            end
            pla_pkg::S_SQRT: begin
                if (adv) begin
                    r_d <= sq_root;
                end
            end
            pla_pkg::S_DIV: begin
                if (adv) begin
                    r_dmag[r_idx[1:0]] <= (r_d == 32'd0) ? 17'd0 : q_clamp;
                    r_idx <= (r_idx == 3'd2) ? 3'd0 : r_idx + 3'd1;
                end
            end
            pla_pkg::S_FALL: begin
                if (adv) begin
                    r_dot  <= '0;
                    r_rd   <= '0;
                    r_n    <= '0;
                    r_ti   <= 4'd1;
                    r_term <= 32'h4000_0000;
                    r_tsum <= 32'h4000_0000;
                    r_x    <= xfull[23:0];
                    if (r_fall == 20'd0) begin
                        r_scale <= 17'(pla_pkg::ONE_Q16);
                    end else begin
                        r_scale <= '0;
                    end
                end
            end
            pla_pkg::S_RED: begin
                if (r_x >= 24'(pla_pkg::LN2_Q16) && r_n != 5'd16) begin
                    r_x <= r_x - 24'(pla_pkg::LN2_Q16);
                    r_n <= r_n + 5'd1;
                end
            end
            pla_pkg::S_TMUL: begin
                if (adv) begin
                    r_tmp <= xfull;
                end
            end
            pla_pkg::S_TDIV: begin
                if (adv) begin
                    r_term  <= div_q[31:0];
                    r_tsum  <= tsum_nx;
                    r_ti    <= r_ti + 4'd1;
                    r_scale <= scale_full[16:0];
                end
            end
            pla_pkg::S_DOT: begin
                if (adv) begin
                    if (r_idx < 3'd3) begin
                        if (r_neg[sel] ^ r_nrm[sel][31]) begin
                            r_dot <= r_dot - 51'(mul_p[47:0]);
                        end else begin
                            r_dot <= r_dot + 51'(mul_p[47:0]);
                        end
                    end else begin
                        if (r_neg[sel] ^ r_rneg[sel]) begin
                            r_rd <= r_rd - 36'(mul_p[33:0]);
                        end else begin
                            r_rd <= r_rd + 36'(mul_p[33:0]);
                        end
                    end
                    r_idx <= (r_idx == 3'd5) ? 3'd0 : r_idx + 3'd1;
                end
            end
            pla_pkg::S_DIF1: begin
                if (adv) begin
                    r_tmp <= xfull;
                end
            end
            pla_pkg::S_PINIT: begin
                if (r_rd <= 36'sd0) begin
                    r_c <= '0;
                end else if (rd_hi > 18'(pla_pkg::ONE_Q16)) begin
                    r_c <= 17'(pla_pkg::ONE_Q16);
                end else begin
                    r_c <= rd_hi[16:0];
                end
                r_p <= 17'(pla_pkg::ONE_Q16);
                r_k <= '0;
            end
            pla_pkg::S_POW: begin
                if (adv && !pow_end) begin
                    r_p <= mul_p[32:16];
                    r_k <= r_k + 8'd1;
                end
            end
            pla_pkg::S_SPC1: begin
                if (adv) begin
                    r_tmp <= xfull;
                end
            end
            pla_pkg::S_SPC2: begin
                r_idx <= '0;
                r_sub <= '0;
            end
            pla_pkg::S_OUT: begin
                if (adv) begin
                    case (r_sub)
                        2'd0: begin
                            r_acc <= 34'(prod_hi);
                            r_sub <= 2'd1;
                        end
                        2'd1: begin
                            r_acc <= acc_sum[33:0];
                            r_sub <= 2'd2;
                        end
                        default: begin
                            r_shade[r_idx[1:0]] <= (|r_acc[33:24]) ? 24'hFF_FFFF : r_acc[23:0];
                            r_amb[r_idx[1:0]] <= (amb_val > 48'(pla_pkg::ONE_Q16)) ?
                                17'(pla_pkg::ONE_Q16) : amb_val[16:0];
                            r_sub <= 2'd0;
                            r_idx <= r_idx + 3'd1;
                        end
                    endcase
                end
            end
            pla_pkg::S_EMIT: begin
                if (emit) begin
                    r_out.shade_red     <= r_shade[0];
                    r_out.shade_green   <= r_shade[1];
                    r_out.shade_blue    <= r_shade[2];
                    r_out.ambient_red   <= r_amb[0];
                    r_out.ambient_green <= r_amb[1];
                    r_out.ambient_blue  <= r_amb[2];
                end
            end
            default: ;
        endcase
    end

    pla_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (m_a),
        .i_b     (m_b),
        .o_done  (mul_done),
        .o_p     (mul_p)
    );

    pla_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (d_dividend),
        .i_divisor  (d_divisor),
        .i_qbits    (d_qbits),
        .o_done     (div_done),
        .o_quo      (div_q)
    );

    pla_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_rad   (r_d2),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );
endmodule

// ----- rtl/core/pla_chk.sv -----
// Port-level checks for the Phong light accumulator, bound to the top level.
// Depends on pla_pkg and phong_light_accumulate_top.
module pla_chk (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_stall,
    input pla_pkg::t_in              i_in_data,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input pla_pkg::t_out             o_out_data,
    input logic                      i_cfg_we,
    input logic [2:0]                i_cfg_idx,
    input logic [pla_pkg::CFG_W-1:0] i_cfg_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result dropped or changed");

    a_light_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.op == pla_pkg::OP_LIGHT |=> o_in_stall)
        else $error("light request did not occupy the sequencer");

    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result raised while idle");

    a_ambient_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.ambient_red <= 17'd65536 &&
            o_out_data.ambient_green <= 17'd65536 && o_out_data.ambient_blue <= 17'd65536)
        else $error("ambient term above one");
endmodule

bind phong_light_accumulate_top pla_chk u_pla_chk (.*);
